// File: hw/rtl/tlc_pkg.sv
// tlc_pkg: shared types, codes and default sizes for the two-level lru tag model
// used by tlc_cell, tlc_level, the top level and its checker
package tlc_pkg;

    localparam int MAX_SETS_DEF  = 256;
    localparam int MAX_WAYS_DEF  = 16;
    localparam int ADDR_BITS_DEF = 13;

    localparam int ROW_W    = 8;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 4;

    // result status codes
    localparam logic [1:0] ST_STORE = 2'd0;
    localparam logic [1:0] ST_HIT   = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_L1_SETS  = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_L1_WAYS  = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_L1_BLOCK = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_L2_EN    = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_L2_SETS  = 3'd4;
    localparam logic [CFG_IX_W-1:0] CFG_L2_WAYS  = 3'd5;
    localparam logic [CFG_IX_W-1:0] CFG_L2_BLOCK = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_L1_GO,
        S_L1_WAIT,
        S_PUT1,
        S_L2_GO,
        S_L2_WAIT,
        S_PUT2
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOAD,
        PH_UPD,
        PH_WR
    } t_lvl_ph;

    typedef struct packed {
        logic load;
        logic shift;
        logic ins;
    } t_cell_ctl;

endpackage

// File: hw/rtl/two_level_lru_cache_tag_model.sv
// two_level_lru_cache_tag_model: top level, access sequencer, config and result register
// depends on tlc_pkg and tlc_level
//
//   channel  signals                                   direction
//   in       i_in_valid / o_in_stall, access fields    to block
//   out      o_out_valid / i_out_stall, result fields  from block
//   cfg      i_cfg_valid / o_cfg_ready, index, data    to block
//
// each level works through set read, load into the way chain, lru update and write back
// an access goes on to L2 when L2 is enabled and it is a store or misses in L1
// the next access is taken once the last result sits in the output register
// reset clears the set valid bits, so no clearing pass is needed
// a stalled output holds its result; the sequencer waits for the register to free
module two_level_lru_cache_tag_model #(
    parameter int MAX_SETS  = tlc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = tlc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = tlc_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ADDR_BITS-1:0]          i_mem_address,
    input  logic                          i_is_store,
    input  logic [12:0]                   i_instr_addr,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_level,
    output logic [1:0]                    o_status,
    output logic [tlc_pkg::ROW_W-1:0]     o_row,
    output logic [ADDR_BITS-1:0]          o_echo_address,
    output logic [12:0]                   o_echo_instr,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tlc_pkg::CFG_IX_W-1:0]  i_cfg_index,
    input  logic [tlc_pkg::CFG_D_W-1:0]   i_cfg_data
);
    import tlc_pkg::*;

    localparam int SETS_LOG2 = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_W     = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;

    t_state r_state, n_state;

    logic [3:0] r_l1_sets, r_l2_sets;
    logic [2:0] r_l1_ways, r_l1_block, r_l2_ways, r_l2_block;
    logic       r_l2_en;

    logic [ADDR_BITS-1:0] r_addr;
    logic [12:0] r_instr;
    logic        r_store;
    logic        r_hit1;
    logic [SET_W-1:0] r_row1;

    logic             l1_start, l2_start, l1_done, l2_done, l1_hit, l2_hit;
    logic [SET_W-1:0] l1_row, l2_row;
    logic             out_free, put1, put2, go_l2, in_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_sets  <= '0;
            r_l1_ways  <= '0;
            r_l1_block <= '0;
            r_l2_en    <= 1'b0;
            r_l2_sets  <= '0;
            r_l2_ways  <= '0;
            r_l2_block <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_L1_SETS:  r_l1_sets  <= i_cfg_data;
                CFG_L1_WAYS:  r_l1_ways  <= i_cfg_data[2:0];
                CFG_L1_BLOCK: r_l1_block <= i_cfg_data[2:0];
                CFG_L2_EN:    r_l2_en    <= i_cfg_data[0];
                CFG_L2_SETS:  r_l2_sets  <= i_cfg_data;
                CFG_L2_WAYS:  r_l2_ways  <= i_cfg_data[2:0];
                CFG_L2_BLOCK: r_l2_block <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    tlc_level #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_l1 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (l1_start),
        .i_addr       (r_addr),
        .i_sets_log2  (r_l1_sets),
        .i_ways_log2  (r_l1_ways),
        .i_block_log2 (r_l1_block),
        .o_done       (l1_done),
        .o_hit        (l1_hit),
        .o_row        (l1_row)
    );

    tlc_level #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_l2 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (l2_start),
        .i_addr       (r_addr),
        .i_sets_log2  (r_l2_sets),
        .i_ways_log2  (r_l2_ways),
        .i_block_log2 (r_l2_block),
        .o_done       (l2_done),
        .o_hit        (l2_hit),
        .o_row        (l2_row)
    );

    assign out_free = !o_out_valid || !i_out_stall;
    assign go_l2    = r_l2_en && (r_store || !r_hit1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_L1_GO;
            S_L1_GO:   n_state = S_L1_WAIT;
            S_L1_WAIT: if (l1_done) n_state = S_PUT1;
            S_PUT1:    if (out_free) n_state = go_l2 ? S_L2_GO : S_IDLE;
            S_L2_GO:   n_state = S_L2_WAIT;
            S_L2_WAIT: if (l2_done) n_state = S_PUT2;
            S_PUT2:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        in_take    = (r_state == S_IDLE) && i_in_valid;
        l1_start   = (r_state == S_L1_GO);
        l2_start   = (r_state == S_L2_GO);
        put1       = (r_state == S_PUT1) && out_free;
        put2       = (r_state == S_PUT2) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_addr  <= i_mem_address;
            r_store <= i_is_store;
            r_instr <= i_instr_addr;
        end
        if (r_state == S_L1_WAIT && l1_done) begin
            r_hit1 <= l1_hit;
            r_row1 <= l1_row;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (put1 || put2) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put1) begin
            o_level  <= 1'b0;
            o_status <= r_store ? ST_STORE : (r_hit1 ? ST_HIT : ST_MISS);
            o_row    <= ROW_W'(r_row1);
            o_last   <= !go_l2;
        end else if (put2) begin
            o_level  <= 1'b1;
            o_status <= r_store ? ST_STORE : (l2_hit ? ST_HIT : ST_MISS);
            o_row    <= ROW_W'(l2_row);
            o_last   <= 1'b1;
        end
        if (put1 || put2) begin
            o_echo_address <= r_addr;
            o_echo_instr   <= r_instr;
        end
    end

endmodule

// File: hw/rtl/tlc_cell.sv
// tlc_cell: one way of the set under work, holds a valid bit and a tag
// depends on tlc_pkg for the control struct
module tlc_cell #(
    parameter int ADDR_BITS = tlc_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  tlc_pkg::t_cell_ctl   i_ctl,
    input  logic [ADDR_BITS:0]   i_load_ent,
    input  logic [ADDR_BITS:0]   i_nb_ent,
    input  logic [ADDR_BITS-1:0] i_key,
    output logic [ADDR_BITS:0]   o_ent,
    output logic                 o_match
);
    import tlc_pkg::*;

    logic [ADDR_BITS:0] r_ent;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ent <= i_load_ent;
        end else if (i_ctl.ins) begin
            r_ent <= {1'b1, i_key};
        end else if (i_ctl.shift) begin
            r_ent <= i_nb_ent;
        end
    end

    assign o_ent   = r_ent;
    assign o_match = r_ent[ADDR_BITS] && (r_ent[ADDR_BITS-1:0] == i_key);

endmodule

// File: hw/rtl/tlc_level.sv
// tlc_level: one cache level, set memory plus a chain of way cells
// depends on tlc_pkg and tlc_cell
module tlc_level #(
    parameter int MAX_SETS  = tlc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = tlc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = tlc_pkg::ADDR_BITS_DEF,
    localparam int SETS_LOG2 = $clog2(MAX_SETS + 1) - 1,
    localparam int SET_W     = (SETS_LOG2 > 0) ? SETS_LOG2 : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [3:0]           i_sets_log2,
    input  logic [2:0]           i_ways_log2,
    input  logic [2:0]           i_block_log2,
    output logic                 o_done,
    output logic                 o_hit,
    output logic [SET_W-1:0]     o_row
);
    import tlc_pkg::*;

    localparam int WAYS_LOG2 = $clog2(MAX_WAYS + 1) - 1;
    localparam int WCNT_W    = WAYS_LOG2 + 1;
    localparam int ENT_W     = ADDR_BITS + 1;
    localparam int MEM_W     = MAX_WAYS * ENT_W;

    t_lvl_ph r_ph, n_ph;

    logic [MEM_W-1:0]     r_mem [MAX_SETS];
    logic [MEM_W-1:0]     r_rd;
    logic                 r_rowv_bits [MAX_SETS];
    logic                 r_rowv;
    logic [SET_W-1:0]     r_row;
    logic [ADDR_BITS-1:0] r_tag;
    logic                 r_hit;

    logic [3:0]           s_eff;
    logic [2:0]           w_eff;
    logic [ADDR_BITS-1:0] blk;
    logic [ADDR_BITS-1:0] row_full;
    logic [ADDR_BITS-1:0] tag_c;
    logic [WCNT_W-1:0]    nways;
    logic [WCNT_W-1:0]    pos;
    logic                 hit_c;
    logic [MAX_WAYS-1:0]  match;
    logic [ENT_W-1:0]     ent [MAX_WAYS];
    t_cell_ctl            ctl [MAX_WAYS];
    logic [MEM_W-1:0]     wdata;

    // geometry, oversized set and way sizes clamp to the largest that fits
    always_comb begin
        s_eff    = (i_sets_log2 > 4'(SETS_LOG2)) ? 4'(SETS_LOG2) : i_sets_log2;
        w_eff    = (i_ways_log2 > 3'(WAYS_LOG2)) ? 3'(WAYS_LOG2) : i_ways_log2;
        blk      = i_addr >> i_block_log2;
        row_full = blk & ~({ADDR_BITS{1'b1}} << s_eff);
        tag_c    = blk >> s_eff;
        nways    = WCNT_W'(1) << w_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
        end else begin
            r_ph <= n_ph;
        end
    end

    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            PH_IDLE: if (i_start) n_ph = PH_LOAD;
            PH_LOAD: n_ph = PH_UPD;
            PH_UPD:  n_ph = PH_WR;
            PH_WR:   n_ph = PH_IDLE;
            default: n_ph = PH_IDLE;
        endcase
    end

    // first match among active ways, else the lru way at the bottom
    always_comb begin
        pos   = '0;
        hit_c = 1'b0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i] && (WCNT_W'(i) < nways)) begin
                pos   = WCNT_W'(i);
                hit_c = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            ctl[i].load  = (r_ph == PH_LOAD);
            ctl[i].shift = (r_ph == PH_UPD) && (WCNT_W'(i) >= pos)
                           && (WCNT_W'(i) < nways - WCNT_W'(1));
            ctl[i].ins   = (r_ph == PH_UPD) && (WCNT_W'(i) == nways - WCNT_W'(1));
            wdata[i*ENT_W +: ENT_W] = ent[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_WAYS; g++) begin : g_cell
            logic [ENT_W-1:0] nb;
            if (g == MAX_WAYS - 1) begin : g_end
                assign nb = '0;
            end else begin : g_mid
                assign nb = ent[g+1];
            end
            tlc_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl[g]),
                .i_load_ent ({r_rd[g*ENT_W+ADDR_BITS] & r_rowv,
                              r_rd[g*ENT_W +: ADDR_BITS]}),
                .i_nb_ent   (nb),
                .i_key      (r_tag),
                .o_ent      (ent[g]),
                .o_match    (match[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (r_ph == PH_IDLE && i_start) begin
            r_rd <= r_mem[SET_W'(row_full)];
        end
        if (r_ph == PH_WR) begin
            r_mem[r_row] <= wdata;
        end
    end

    // a set never written reads as all invalid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SETS; i++) begin
                r_rowv_bits[i] <= 1'b0;
            end
        end else if (r_ph == PH_WR) begin
            r_rowv_bits[r_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == PH_IDLE && i_start) begin
            r_row  <= SET_W'(row_full);
            r_tag  <= tag_c;
            r_rowv <= r_rowv_bits[SET_W'(row_full)];
        end
        if (r_ph == PH_UPD) begin
            r_hit <= hit_c;
        end
    end

    assign o_done = (r_ph == PH_WR);
    assign o_hit  = r_hit;
    assign o_row  = r_row;

endmodule

// File: hw/rtl/tlc_checker.sv
// tlc_checker: port-level checks on the result channel of the tag model
// depends on tlc_pkg; bound to two_level_lru_cache_tag_model below
module tlc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_in_stall,
    input logic                      o_level,
    input logic [1:0]                o_status,
    input logic [tlc_pkg::ROW_W-1:0] o_row,
    input logic                      o_last
);
    import tlc_pkg::*;

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_row) && $stable(o_level) && $stable(o_last))
        else $error("stalled result changed");

    a_l2_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_level |-> o_last)
        else $error("l2 report not last");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_STORE || o_status == ST_HIT
            || o_status == ST_MISS))
        else $error("bad status code");

    // no new access is taken while the l2 report of one is still owed
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && !o_level |-> o_in_stall)
        else $error("access taken before its l2 report");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind two_level_lru_cache_tag_model tlc_checker u_tlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_in_stall  (o_in_stall),
    .o_level     (o_level),
    .o_status    (o_status),
    .o_row       (o_row),
    .o_last      (o_last)
);
